@@ src/prefix_table_with_aging_macros.svh @@
// ----------------------------------------------------------------------------
// Prefix table with aging: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_TABLE_WITH_AGING_MACROS_SVH
`define PREFIX_TABLE_WITH_AGING_MACROS_SVH

// same-cycle implication
`define PTA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pta: same-cycle check failed");

// next-cycle implication
`define PTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pta: next-cycle check failed");

`endif

@@ src/pta_pkg.sv @@
// ----------------------------------------------------------------------------
// Prefix table with aging: package
// Table sizing, field widths, entry and result types, walk states.
// ----------------------------------------------------------------------------
package pta_pkg;

    localparam int TABLE_DEPTH   = 32;
    localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

    localparam int PH_W          = 32;
    localparam int PL_W          = 64;
    localparam int TIME_W        = 32;
    localparam int ENTRY_INDEX_W = 5;
    localparam int ALLOC_W       = 6;

    localparam logic [TIME_W-1:0] EXPIRY_RESET = TIME_W'(100);

    typedef struct packed {
        logic [PH_W-1:0]   prefix_high;
        logic [PL_W-1:0]   prefix_low;
        logic [TIME_W-1:0] last_time;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic                     was_matched;
        logic                     was_reused;
        logic                     table_full;
        logic [ALLOC_W-1:0]       allocated_entries;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

@@ src/pta_req_if.sv @@
// ----------------------------------------------------------------------------
// Prefix table with aging: request channel
// Valid/ready channel carrying one lookup word: prefix and current time.
// ----------------------------------------------------------------------------
interface pta_req_if;
    logic                      valid;
    logic                      ready;
    logic [pta_pkg::PH_W-1:0]   prefix_high;
    logic [pta_pkg::PL_W-1:0]   prefix_low;
    logic [pta_pkg::TIME_W-1:0] now_seconds;

    modport source(output valid, output prefix_high, output prefix_low,
                   output now_seconds, input ready);
    modport sink(input valid, input prefix_high, input prefix_low,
                 input now_seconds, output ready);
endinterface

@@ src/pta_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Prefix table with aging: response channel
// Valid/ready channel carrying one result word per lookup.
// ----------------------------------------------------------------------------
interface pta_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [pta_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic                              was_matched;
    logic                              was_reused;
    logic                              table_full;
    logic [pta_pkg::ALLOC_W-1:0]       allocated_entries;

    modport source(output valid, output entry_index, output was_matched,
                   output was_reused, output table_full, output allocated_entries,
                   input ready);
    modport sink(input valid, input entry_index, input was_matched,
                 input was_reused, input table_full, input allocated_entries,
                 output ready);
endinterface

@@ src/pta_ram.sv @@
// ----------------------------------------------------------------------------
// Prefix table with aging: entry memory
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pta_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/pta_ctrl.sv @@
// ----------------------------------------------------------------------------
// Prefix table with aging: walk controller
// Walks allocated entries, ages them, finds a match or a free slot, writes back.
// ----------------------------------------------------------------------------
module pta_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pta_pkg::TIME_W-1:0]   i_expiry,
    pta_req_if.sink                      i_req,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output pta_pkg::t_result             o_res,
    output logic                         o_ram_we,
    output logic [pta_pkg::IDX_W-1:0]    o_ram_waddr,
    output pta_pkg::t_entry              o_ram_wdata,
    output logic [pta_pkg::IDX_W-1:0]    o_ram_raddr,
    input  pta_pkg::t_entry              i_ram_rdata
);
    pta_pkg::t_state r_state, n_state;

    logic [pta_pkg::CNT_W-1:0]       r_count;
    logic [pta_pkg::CNT_W-1:0]       r_pos;
    logic [pta_pkg::TABLE_DEPTH-1:0] r_in_use;
    logic                            r_matched;
    logic                            r_reused;
    logic                            r_full;
    logic                            r_free_found;
    logic [pta_pkg::IDX_W-1:0]       r_free_idx;
    logic [pta_pkg::IDX_W-1:0]       r_res_idx;

    logic [pta_pkg::PH_W-1:0]        r_ph;
    logic [pta_pkg::PL_W-1:0]        r_pl;
    logic [pta_pkg::TIME_W-1:0]      r_now;

    logic [pta_pkg::TIME_W-1:0]      w_age;
    logic                            w_stale;
    logic                            w_hit;
    logic                            w_last;
    logic                            w_room;
    logic [pta_pkg::IDX_W-1:0]       w_pos_idx;
    logic [pta_pkg::IDX_W-1:0]       w_sel_idx;
    logic                            w_accept;

    assign w_pos_idx = r_pos[pta_pkg::IDX_W-1:0];
    assign w_age     = r_now - i_ram_rdata.last_time;
    assign w_stale   = w_age > i_expiry;
    assign w_hit     = (i_ram_rdata.prefix_high == r_ph) && (i_ram_rdata.prefix_low == r_pl);
    assign w_last    = (r_pos + pta_pkg::CNT_W'(1)) == r_count;
    assign w_room    = r_count < pta_pkg::CNT_W'(pta_pkg::TABLE_DEPTH);
    assign w_sel_idx = r_matched    ? r_res_idx  :
                       r_free_found ? r_free_idx : r_count[pta_pkg::IDX_W-1:0];
    assign w_accept  = i_req.valid && i_req.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pta_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = (r_count == '0) ? pta_pkg::S_WRITE : pta_pkg::S_READ;
                end
            end
            pta_pkg::S_READ: begin
                n_state = pta_pkg::S_CHECK;
            end
            pta_pkg::S_CHECK: begin
                if ((!w_stale && w_hit) || w_last) begin
                    n_state = pta_pkg::S_WRITE;
                end else begin
                    n_state = pta_pkg::S_READ;
                end
            end
            pta_pkg::S_WRITE: begin
                n_state = pta_pkg::S_DONE;
            end
            pta_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = pta_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pta_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready = 1'b0;
        o_res_valid = 1'b0;
        o_ram_we    = 1'b0;
        case (r_state)
            pta_pkg::S_IDLE:  i_req.ready = 1'b1;
            pta_pkg::S_WRITE: o_ram_we    = r_matched || r_free_found || w_room;
            pta_pkg::S_DONE:  o_res_valid = 1'b1;
            default: begin
                o_ram_we = 1'b0;
            end
        endcase
    end

    assign o_ram_raddr = w_pos_idx;
    assign o_ram_waddr = w_sel_idx;
    assign o_ram_wdata = '{prefix_high: r_ph, prefix_low: r_pl, last_time: r_now};

    assign o_res.entry_index       = pta_pkg::ENTRY_INDEX_W'(r_res_idx);
    assign o_res.was_matched       = r_matched;
    assign o_res.was_reused        = r_reused;
    assign o_res.table_full        = r_full;
    assign o_res.allocated_entries = pta_pkg::ALLOC_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pta_pkg::S_IDLE;
            r_count      <= '0;
            r_pos        <= '0;
            r_in_use     <= '0;
            r_matched    <= 1'b0;
            r_reused     <= 1'b0;
            r_full       <= 1'b0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_res_idx    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                pta_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_pos        <= '0;
                        r_matched    <= 1'b0;
                        r_reused     <= 1'b0;
                        r_full       <= 1'b0;
                        r_free_found <= 1'b0;
                    end
                end
                pta_pkg::S_CHECK: begin
                    r_pos <= r_pos + pta_pkg::CNT_W'(1);
                    if (w_stale) begin
                        r_in_use[w_pos_idx] <= 1'b0;
                        if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= w_pos_idx;
                        end
                    end else if (w_hit) begin
                        r_matched <= 1'b1;
                        r_res_idx <= w_pos_idx;
                    end else if (!r_in_use[w_pos_idx] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= w_pos_idx;
                    end
                end
                pta_pkg::S_WRITE: begin
                    if (r_matched) begin
                        r_res_idx <= w_sel_idx;
                    end else if (r_free_found) begin
                        r_res_idx           <= w_sel_idx;
                        r_reused            <= 1'b1;
                        r_in_use[w_sel_idx] <= 1'b1;
                    end else if (w_room) begin
                        r_res_idx           <= w_sel_idx;
                        r_in_use[w_sel_idx] <= 1'b1;
                        r_count             <= r_count + pta_pkg::CNT_W'(1);
                    end else begin
                        r_res_idx <= '0;
                        r_full    <= 1'b1;
                    end
                end
                default: begin
                    r_pos <= r_pos;
                end
            endcase
        end
    end

    // hold the request word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ph  <= i_req.prefix_high;
            r_pl  <= i_req.prefix_low;
            r_now <= i_req.now_seconds;
        end
    end
endmodule

@@ src/prefix_table_with_aging.sv @@
// ----------------------------------------------------------------------------
// Prefix table with aging: top level
// Lookup/allocate table of 96-bit prefixes with expiry-based aging.
// ----------------------------------------------------------------------------
// One request word is taken at a time. It walks the allocated entries (at most
// 32) in index order through the single read port of the entry memory, reading
// and then checking each entry, and stops early on a fresh match; a write-back
// state and a hand-off state follow, and the hand-off waits while the output
// register holds an untaken result. The result sits in an output register, so a
// new request may be taken while the previous result waits. expiry_seconds
// resets to 100 and is written through i_cfg_we / i_cfg_data; the user must write
// it only while the block is idle, and the block itself does not enforce this.
`include "prefix_table_with_aging_macros.svh"

module prefix_table_with_aging (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pta_pkg::TIME_W-1:0] i_cfg_data,
    pta_req_if.sink                    i_req,
    pta_rsp_if.source                  o_rsp
);
    logic [pta_pkg::TIME_W-1:0] r_expiry;
    logic                       r_out_valid;
    pta_pkg::t_result           r_out;

    logic                       w_res_valid;
    logic                       w_res_ready;
    pta_pkg::t_result           w_res;
    logic                       w_ram_we;
    logic [pta_pkg::IDX_W-1:0]  w_ram_waddr;
    logic [pta_pkg::IDX_W-1:0]  w_ram_raddr;
    pta_pkg::t_entry            w_ram_wdata;
    pta_pkg::t_entry            w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= pta_pkg::EXPIRY_RESET;
        end else if (i_cfg_we) begin
            r_expiry <= i_cfg_data;
        end
    end

    pta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_expiry    (r_expiry),
        .i_req       (i_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    pta_ram #(
        .WIDTH (pta_pkg::ENTRY_W),
        .DEPTH (pta_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.entry_index       = r_out.entry_index;
    assign o_rsp.was_matched       = r_out.was_matched;
    assign o_rsp.was_reused        = r_out.was_reused;
    assign o_rsp.table_full        = r_out.table_full;
    assign o_rsp.allocated_entries = r_out.allocated_entries;

    `PTA_ASSERT_IMPL(a_full_at_depth, o_rsp.valid && o_rsp.table_full, o_rsp.allocated_entries == pta_pkg::ALLOC_W'(pta_pkg::TABLE_DEPTH) && !o_rsp.was_matched && !o_rsp.was_reused)
    `PTA_ASSERT_IMPL(a_match_reuse_excl, o_rsp.valid, !(o_rsp.was_matched && o_rsp.was_reused))
    `PTA_ASSERT_NEXT(a_busy_after_accept, i_req.valid && i_req.ready, !i_req.ready)
    `PTA_ASSERT_IMPL(a_no_write_when_full, w_res_valid && w_res.table_full, !w_ram_we)
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prefix table with aging: testbench
// Sends lookup words (prefix plus current time) with random gaps and random
// result stalls. Each lookup is also run through a behavioral copy of the
// table in this file, and every result word is compared field by field with
// the oldest prediction. Covers append, match, reuse, aging at the boundary,
// time wrap, a full table and a long result stall, under several expiry
// settings.
// ----------------------------------------------------------------------------
module tb;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_SIZE   = 24;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [pta_pkg::TIME_W-1:0] i_cfg_data;

    pta_req_if req ();
    pta_rsp_if rsp ();

    prefix_table_with_aging dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req.sink),
        .o_rsp      (rsp.source)
    );

    logic [pta_pkg::PH_W-1:0]   shadow_ph    [pta_pkg::TABLE_DEPTH];
    logic [pta_pkg::PL_W-1:0]   shadow_pl    [pta_pkg::TABLE_DEPTH];
    logic [pta_pkg::TIME_W-1:0] shadow_stamp [pta_pkg::TABLE_DEPTH];
    bit                         shadow_live  [pta_pkg::TABLE_DEPTH];
    int                         shadow_count;
    logic [pta_pkg::TIME_W-1:0] shadow_expiry;

    pta_pkg::t_result pending_results [$];

    bit gaps_on;
    int hold_requests;
    int mismatches;
    int cycle_count;
    int n_items, n_matched, n_reused, n_appended, n_full, n_checked;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic pta_pkg::t_result predict_lookup(
            input logic [pta_pkg::PH_W-1:0] ph,
            input logic [pta_pkg::PL_W-1:0] pl,
            input logic [pta_pkg::TIME_W-1:0] now);
        pta_pkg::t_result r;
        logic [pta_pkg::TIME_W-1:0] age;
        int slot;
        bit hit, matched, reused, full;
        slot = 0;
        hit = 0;
        matched = 0;
        reused = 0;
        full = 0;
        for (int i = 0; i < shadow_count && !hit; i++) begin
            age = now - shadow_stamp[i];
            if (age > shadow_expiry) begin
                shadow_live[i] = 1'b0;
            end else if (shadow_ph[i] == ph && shadow_pl[i] == pl) begin
                slot = i;
                hit = 1;
                matched = 1;
            end
        end
        if (!hit) begin
            for (int i = 0; i < shadow_count && !hit; i++) begin
                if (!shadow_live[i]) begin
                    slot = i;
                    hit = 1;
                    reused = 1;
                end
            end
            if (!hit) begin
                if (shadow_count < pta_pkg::TABLE_DEPTH) begin
                    slot = shadow_count;
                    hit = 1;
                    shadow_count++;
                end else begin
                    full = 1;
                end
            end
            if (hit) begin
                shadow_ph[slot]   = ph;
                shadow_pl[slot]   = pl;
                shadow_live[slot] = 1'b1;
            end
        end
        if (hit) shadow_stamp[slot] = now;
        r.entry_index       = full ? '0 : pta_pkg::ENTRY_INDEX_W'(slot);
        r.was_matched       = matched;
        r.was_reused        = reused;
        r.table_full        = full;
        r.allocated_entries = pta_pkg::ALLOC_W'(shadow_count);
        return r;
    endfunction

    task automatic send_lookup(input logic [pta_pkg::PH_W-1:0] ph,
                               input logic [pta_pkg::PL_W-1:0] pl,
                               input logic [pta_pkg::TIME_W-1:0] now);
        int unsigned gap;
        pta_pkg::t_result word;
        gap = gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.prefix_high <= ph;
        req.prefix_low  <= pl;
        req.now_seconds <= now;
        do @(posedge i_clk); while (req.ready !== 1'b1);
        word = predict_lookup(ph, pl, now);
        pending_results = {pending_results, word};
        n_items++;
        if (word.table_full) n_full++;
        else if (word.was_matched) n_matched++;
        else if (word.was_reused) n_reused++;
        else n_appended++;
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_expiry(input logic [pta_pkg::TIME_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_expiry = value;
    endtask

    function automatic logic [pta_pkg::TIME_W-1:0] next_time(
            input logic [pta_pkg::TIME_W-1:0] t,
            input logic [pta_pkg::TIME_W-1:0] e);
        int unsigned span, r;
        span = (e > 2000) ? 2000 : e + 1;
        r = $urandom_range(0, 99);
        if (r < 55) return t + $urandom_range(0, 2);
        if (r < 85) return t + $urandom_range(0, span);
        if (r < 96) return t + $urandom_range(span, 3 * span);
        return $urandom;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        pta_pkg::t_result want;
        if (i_rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result word with no lookup outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("entry_index", 64'(want.entry_index),
                            64'(rsp.entry_index));
                check_field("was_matched", 64'(want.was_matched),
                            64'(rsp.was_matched));
                check_field("was_reused", 64'(want.was_reused),
                            64'(rsp.was_reused));
                check_field("table_full", 64'(want.table_full),
                            64'(rsp.table_full));
                check_field("allocated_entries", 64'(want.allocated_entries),
                            64'(rsp.allocated_entries));
            end
        end
    end

    initial begin : rsp_ready_drive
        int unsigned stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        rsp.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                rsp.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic test_directed();
        // expiry is still at its reset value of 100
        send_lookup('1, '1, 32'd10);
        send_lookup('0, '0, 32'd10);
        send_lookup('1, '1, 32'd110);
        send_lookup(32'h1234_5678, 64'h0F0F_0F0F_F0F0_F0F0, 32'd211);
        send_lookup('0, '0, 32'd50);
        send_lookup(32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 32'd50);
        send_lookup(32'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5, 32'd50);
        send_lookup('1, '1, 32'hFFFF_FFC0);
        send_lookup('1, '1, 32'h0000_0010);
        send_lookup(32'h0000_0001, 64'h8000_0000_0000_0000, 32'h0000_0010);
        send_lookup('1, '1, 32'h0000_0060);
        send_lookup('1, '1, 32'h0000_0075);
        send_lookup(32'h8000_0000, 64'h0000_0000_0000_0001, 32'h0000_0020);
        send_lookup(32'hCAFE_0000, 64'h0000_0000_DEAD_0000, 32'h0000_0020);
        send_lookup('1, '0, 32'h0000_0020);
        send_lookup('0, '1, 32'h0000_0020);
        send_lookup('1, '1, 32'h0000_0020);
        send_lookup('1, '0, 32'h0000_0021);
        send_lookup('0, '1, 32'h0000_0021);
        send_lookup(32'hCAFE_0000, 64'h0000_0000_DEAD_0000, 32'hFFFF_FFFF);
        send_lookup('0, '0, 32'h0000_0000);
        wait_drained();
    endtask

    task automatic test_random_phase(input logic [pta_pkg::TIME_W-1:0] expiry,
                                     input int items, input bit with_gaps);
        logic [pta_pkg::PH_W-1:0]   pool_ph [POOL_SIZE];
        logic [pta_pkg::PL_W-1:0]   pool_pl [POOL_SIZE];
        logic [pta_pkg::TIME_W-1:0] now;
        int src, b, k;
        set_expiry(expiry);
        gaps_on <= with_gaps;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i > 0 && $urandom_range(0, 3) == 0) begin
                // near miss: one bit away from an earlier prefix
                src = $urandom_range(0, i - 1);
                b = $urandom_range(0, pta_pkg::PH_W + pta_pkg::PL_W - 1);
                pool_ph[i] = pool_ph[src];
                pool_pl[i] = pool_pl[src];
                if (b < pta_pkg::PL_W) pool_pl[i][b] = ~pool_pl[i][b];
                else pool_ph[i][b - pta_pkg::PL_W] = ~pool_ph[i][b - pta_pkg::PL_W];
            end else begin
                pool_ph[i] = $urandom;
                pool_pl[i] = {$urandom, $urandom};
            end
        end
        now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF80 : $urandom;
        for (int n = 0; n < items; n++) begin
            now = next_time(now, expiry);
            if ($urandom_range(0, 99) < 85) begin
                k = $urandom_range(0, POOL_SIZE - 1);
                send_lookup(pool_ph[k], pool_pl[k], now);
            end else begin
                send_lookup($urandom, {$urandom, $urandom}, now);
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        logic [pta_pkg::TIME_W-1:0] now;
        gaps_on <= 1'b0;
        hold_requests <= hold_requests + 1;
        now = $urandom;
        for (int n = 0; n < 8; n++) begin
            send_lookup(32'h0000_00C0 + n[1:0], {$urandom, $urandom}, now);
            now = now + 1;
        end
        wait_drained();
    endtask

    task automatic test_full_table();
        logic [pta_pkg::TIME_W-1:0] now;
        bit open;
        set_expiry('1);
        gaps_on <= 1'b1;
        now = 32'h8000_0000;
        // fill every entry so that none is free
        forever begin
            open = shadow_count < pta_pkg::TABLE_DEPTH;
            for (int i = 0; i < shadow_count; i++) if (!shadow_live[i]) open = 1;
            if (!open) break;
            send_lookup($urandom, {$urandom, $urandom}, now);
            now = now + $urandom_range(0, 5);
        end
        for (int n = 0; n < 3; n++) send_lookup($urandom, {$urandom, $urandom}, now);
        send_lookup(shadow_ph[pta_pkg::TABLE_DEPTH - 1], shadow_pl[pta_pkg::TABLE_DEPTH - 1],
                    now);
        send_lookup(shadow_ph[5], shadow_pl[5], now + 7);
        wait_drained();
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        req.valid       = 1'b0;
        req.prefix_high = '0;
        req.prefix_low  = '0;
        req.now_seconds = '0;
        gaps_on         = 1'b0;
        hold_requests   = 0;
        shadow_count    = 0;
        shadow_expiry   = pta_pkg::EXPIRY_RESET;
        for (int i = 0; i < pta_pkg::TABLE_DEPTH; i++) begin
            shadow_ph[i]    = '0;
            shadow_pl[i]    = '0;
            shadow_stamp[i] = '0;
            shadow_live[i]  = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(32'd0, 120, 1'b1);
        test_random_phase(32'd12, 130, 1'b0);
        test_random_phase(32'd100, 130, 1'b1);
        test_random_phase(32'd3000, 130, 1'b1);
        test_backpressure();
        test_full_table();
        test_random_phase(32'd40, 90, 1'b1);

        wait_drained();
        repeat (70) @(posedge i_clk);
        $display("%0d lookups, %0d results checked: %0d matched, %0d reused, %0d appended,",
                 n_items, n_checked, n_matched, n_reused, n_appended);
        $display("%0d table full; expiry from 0 to all ones, one %0d-cycle result stall.",
                 n_full, HOLD_CYCLES);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
